// ===== rtl/mcmf_pkg.sv =====
// ---------------------------------------------------------------------------
// mcmf_pkg
// Shared sizes, codes and record types for the min-cost max-flow engine.
// ---------------------------------------------------------------------------
package mcmf_pkg;

    localparam int MAX_VERTICES = 1024;
    localparam int MAX_ARCS     = 8192;
    localparam int VW           = $clog2(MAX_VERTICES);
    localparam int AW           = $clog2(MAX_ARCS);
    localparam int EW           = VW + 1;
    localparam int RW           = 16;
    localparam int CW           = 33;
    localparam int DW           = 64;

    localparam logic [1:0] FUNC_CLEAR = 2'd0;
    localparam logic [1:0] FUNC_ADD   = 2'd1;
    localparam logic [1:0] FUNC_SOLVE = 2'd2;
    localparam logic [1:0] FUNC_QUERY = 2'd3;

    localparam logic [1:0] CFG_VERTEX_COUNT = 2'd0;
    localparam logic [1:0] CFG_SOURCE       = 2'd1;
    localparam logic [1:0] CFG_SINK         = 2'd2;

    localparam logic signed [DW-1:0] COST_INF     = 64'sd1000000000000000;
    localparam logic signed [DW-1:0] COST_NEG_INF = -64'sd1000000000000000;

    // arc count above this leaves no room for another arc pair
    localparam logic [AW-1:0] ARC_LIMIT = AW'(MAX_ARCS - 3);

    typedef struct packed {
        logic [AW-1:0]        next;
        logic [VW-1:0]        target;
        logic signed [CW-1:0] cost;
    } t_arc;

    typedef struct packed {
        logic signed [DW-1:0] dval;
        logic [AW-1:0]        parent;
        logic                 inq;
        logic [EW-1:0]        enq;
    } t_vtx;

endpackage

// ===== rtl/min_cost_max_flow_spfa_top.sv =====
// ---------------------------------------------------------------------------
// min_cost_max_flow_spfa_top
// Min-cost max-flow engine: adjacency lists in on-chip memories, successive
// shortest paths with a circular queue search.
// ---------------------------------------------------------------------------
// Usage
//   Requests enter on i_in_valid / o_in_stall, results leave on
//   o_out_valid / i_out_stall; one result per request. Registers are written
//   through i_cfg_we / i_cfg_index / i_cfg_data; the user must write them
//   only while the block is idle, which the block itself does not enforce.
//   Every request runs to completion before the next one is taken; all graph
//   state sits in simple dual-port synchronous memories with registered reads.
//   Add edge makes two head-table updates. Clear sweeps the 1024-entry list
//   head memory. Solve: per search, distance initialisation, then queue pops
//   and arc scans with a relaxation step for each arc whose head is examined,
//   then two path walks and cost accumulation.
//   After reset the whole list head memory is swept with o_in_stall high;
//   configuration writes are still taken during that time.
//   A finished result waits in the output register while the receiver
//   stalls; a new request may be accepted meanwhile, and its result is held
//   back until the output register is free.
// ---------------------------------------------------------------------------
module min_cost_max_flow_spfa_top (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic [1:0]                      i_func,
    input  logic [mcmf_pkg::VW-1:0]         i_from_vertex,
    input  logic [mcmf_pkg::VW-1:0]         i_to_vertex,
    input  logic [15:0]                     i_capacity,
    input  logic signed [31:0]              i_edge_cost,
    input  logic [mcmf_pkg::AW-1:0]         i_arc_index,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic [mcmf_pkg::AW-1:0]         o_new_arc,
    output logic [30:0]                     o_total_flow,
    output logic signed [63:0]              o_total_cost,
    output logic                            o_matched,
    output logic                            o_status,
    input  logic                            i_cfg_we,
    input  logic [1:0]                      i_cfg_index,
    input  logic [mcmf_pkg::VW-1:0]         i_cfg_data
);
    import mcmf_pkg::*;

    localparam logic [4:0] S_IDLE  = 5'd0;
    localparam logic [4:0] S_CLEAR = 5'd1;
    localparam logic [4:0] S_ADD1  = 5'd2;
    localparam logic [4:0] S_ADD2  = 5'd3;
    localparam logic [4:0] S_QRY   = 5'd4;
    localparam logic [4:0] S_INIT  = 5'd5;
    localparam logic [4:0] S_SEED  = 5'd6;
    localparam logic [4:0] S_POP   = 5'd7;
    localparam logic [4:0] S_POP2  = 5'd8;
    localparam logic [4:0] S_POP3  = 5'd9;
    localparam logic [4:0] S_SCAN  = 5'd10;
    localparam logic [4:0] S_ARC   = 5'd11;
    localparam logic [4:0] S_RELAX = 5'd12;
    localparam logic [4:0] S_TCHK  = 5'd13;
    localparam logic [4:0] S_W0    = 5'd14;
    localparam logic [4:0] S_W1    = 5'd15;
    localparam logic [4:0] S_W2    = 5'd16;
    localparam logic [4:0] S_MUL0  = 5'd17;
    localparam logic [4:0] S_MUL1  = 5'd18;
    localparam logic [4:0] S_MUL2  = 5'd19;
    localparam logic [4:0] S_DONE  = 5'd20;

    // memories
    t_arc            r_arc_mem  [MAX_ARCS];
    logic [2*RW-1:0] r_res_mem  [MAX_ARCS/2];
    t_vtx            r_vtx_mem  [MAX_VERTICES];
    logic [AW-1:0]   r_head_mem [MAX_VERTICES];
    logic [VW-1:0]   r_q_mem    [MAX_VERTICES];

    t_arc            r_arc_rd;
    logic [2*RW-1:0] r_res_rd;
    t_vtx            r_vtx_rd;
    logic [AW-1:0]   r_head_rd;
    logic [VW-1:0]   r_q_rd;

    logic            arc_we, res_we, vtx_we, head_we, q_we;
    logic [AW-1:0]   arc_wa, arc_ra;
    logic [AW-2:0]   res_wa, res_ra;
    logic [VW-1:0]   vtx_wa, vtx_ra, head_wa, head_ra, q_wa, q_ra;
    t_arc            arc_wd;
    logic [2*RW-1:0] res_wd;
    t_vtx            vtx_wd;
    logic [AW-1:0]   head_wd;
    logic [VW-1:0]   q_wd;

    // configuration
    logic [VW-1:0] r_lim, r_src, r_snk;

    // control and datapath registers
    logic [4:0]           r_state, n_state;
    logic                 r_boot, n_boot;
    logic [VW-1:0]        r_cnt, n_cnt;
    logic [VW-1:0]        r_u, n_u, r_v, n_v;
    logic [RW-1:0]        r_cap, n_cap;
    logic signed [CW-1:0] r_cost, n_cost;
    logic [AW-1:0]        r_idx, n_idx;
    logic [AW-1:0]        r_arc_count, n_arc_count;
    logic [VW-1:0]        r_qh, n_qh;
    logic [EW-1:0]        r_qlen, n_qlen;
    logic signed [DW-1:0] r_du, n_du, r_nd, n_nd, r_dt, n_dt;
    logic [AW-1:0]        r_a, n_a, r_next, n_next;
    logic [VW-1:0]        r_tgt, n_tgt, r_w, n_w;
    logic [EW-1:0]        r_steps, n_steps;
    logic [RW-1:0]        r_b, n_b;
    logic                 r_pass, n_pass;
    logic [47:0]          r_prod, n_prod;
    logic [30:0]          r_flow, n_flow;
    logic [DW-1:0]        r_cost_acc, n_cost_acc;
    logic [AW-1:0]        r_res_new_arc, n_res_new_arc;
    logic                 r_res_matched, n_res_matched;
    logic                 r_res_status, n_res_status;

    logic                 r_out_valid, n_out_valid;
    logic [AW-1:0]        r_o_new_arc, n_o_new_arc;
    logic [30:0]          r_o_flow, n_o_flow;
    logic [DW-1:0]        r_o_cost, n_o_cost;
    logic                 r_o_matched, n_o_matched;
    logic                 r_o_status, n_o_status;

    logic                 in_acc;
    logic [AW-1:0]        arc_f, arc_r, hv;
    logic [RW-1:0]        half_a, half_q;
    logic [EW-1:0]        lim_p1;
    logic [31:0]          mul_a;
    logic [47:0]          mul_p;

    assign in_acc = i_in_valid && !o_in_stall;
    assign o_in_stall = (r_state != S_IDLE);
    assign arc_f  = r_arc_count + AW'(1);
    assign arc_r  = r_arc_count + AW'(2);
    assign hv     = (r_u == r_v) ? arc_f : r_head_rd;
    assign half_a = r_a[0] ? r_res_rd[2*RW-1:RW] : r_res_rd[RW-1:0];
    assign half_q = r_idx[0] ? r_res_rd[2*RW-1:RW] : r_res_rd[RW-1:0];
    assign lim_p1 = {1'b0, r_lim} + EW'(1);
    assign mul_a  = (r_state == S_MUL0) ? r_dt[31:0] : r_dt[63:32];
    assign mul_p  = {16'b0, mul_a} * {32'b0, r_b};

    assign o_out_valid  = r_out_valid;
    assign o_new_arc    = r_o_new_arc;
    assign o_total_flow = r_o_flow;
    assign o_total_cost = r_o_cost;
    assign o_matched    = r_o_matched;
    assign o_status     = r_o_status;

    always_ff @(posedge i_clk) begin
        if (arc_we) begin
            r_arc_mem[arc_wa] <= arc_wd;
        end
        r_arc_rd <= r_arc_mem[arc_ra];
    end

    always_ff @(posedge i_clk) begin
        if (res_we) begin
            r_res_mem[res_wa] <= res_wd;
        end
        r_res_rd <= r_res_mem[res_ra];
    end

    always_ff @(posedge i_clk) begin
        if (vtx_we) begin
            r_vtx_mem[vtx_wa] <= vtx_wd;
        end
        r_vtx_rd <= r_vtx_mem[vtx_ra];
    end

    always_ff @(posedge i_clk) begin
        if (head_we) begin
            r_head_mem[head_wa] <= head_wd;
        end
        r_head_rd <= r_head_mem[head_ra];
    end

    always_ff @(posedge i_clk) begin
        if (q_we) begin
            r_q_mem[q_wa] <= q_wd;
        end
        r_q_rd <= r_q_mem[q_ra];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lim <= '0;
            r_src <= '0;
            r_snk <= VW'(1);
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_VERTEX_COUNT: r_lim <= i_cfg_data;
                CFG_SOURCE:       r_src <= i_cfg_data;
                CFG_SINK:         r_snk <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        n_state = r_state;  n_boot = r_boot;  n_cnt = r_cnt;
        n_u = r_u;  n_v = r_v;  n_cap = r_cap;  n_cost = r_cost;  n_idx = r_idx;
        n_arc_count = r_arc_count;  n_qh = r_qh;  n_qlen = r_qlen;
        n_du = r_du;  n_nd = r_nd;  n_dt = r_dt;  n_a = r_a;  n_next = r_next;
        n_tgt = r_tgt;  n_w = r_w;  n_steps = r_steps;  n_b = r_b;  n_pass = r_pass;
        n_prod = r_prod;  n_flow = r_flow;  n_cost_acc = r_cost_acc;
        n_res_new_arc = r_res_new_arc;  n_res_matched = r_res_matched;
        n_res_status = r_res_status;
        n_out_valid = r_out_valid;  n_o_new_arc = r_o_new_arc;  n_o_flow = r_o_flow;
        n_o_cost = r_o_cost;  n_o_matched = r_o_matched;  n_o_status = r_o_status;

        arc_we = 1'b0;  arc_wa = '0;  arc_wd = '0;  arc_ra = '0;
        res_we = 1'b0;  res_wa = '0;  res_wd = '0;  res_ra = '0;
        vtx_we = 1'b0;  vtx_wa = '0;  vtx_wd = '0;  vtx_ra = '0;
        head_we = 1'b0; head_wa = '0; head_wd = '0; head_ra = '0;
        q_we = 1'b0;    q_wa = '0;    q_wd = '0;    q_ra = '0;

        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                head_ra = i_from_vertex;
                res_ra  = i_arc_index[AW-1:1];
                if (in_acc) begin
                    n_u = i_from_vertex;
                    n_v = i_to_vertex;
                    n_cap = i_capacity;
                    n_cost = {i_edge_cost[31], i_edge_cost};
                    n_idx = i_arc_index;
                    n_res_new_arc = '0;
                    n_res_matched = 1'b0;
                    n_res_status = 1'b0;
                    n_flow = '0;
                    n_cost_acc = '0;
                    n_cnt = '0;
                    unique case (i_func)
                        FUNC_CLEAR: begin
                            n_arc_count = AW'(1);
                            n_state = S_CLEAR;
                        end
                        FUNC_ADD: begin
                            if (i_from_vertex > r_lim || i_to_vertex > r_lim ||
                                r_arc_count > ARC_LIMIT) begin
                                n_res_status = 1'b1;
                                n_state = S_DONE;
                            end else begin
                                n_state = S_ADD1;
                            end
                        end
                        FUNC_SOLVE: begin
                            if (r_src > r_lim || r_snk > r_lim || r_src == r_snk) begin
                                n_state = S_DONE;
                            end else begin
                                n_state = S_INIT;
                            end
                        end
                        FUNC_QUERY: n_state = S_QRY;
                        default:    n_state = S_IDLE;
                    endcase
                end
            end
            S_CLEAR: begin
                head_we = 1'b1;
                head_wa = r_cnt;
                head_wd = '0;
                n_cnt = r_cnt + VW'(1);
                if (r_cnt == VW'(MAX_VERTICES - 1)) begin
                    n_boot = 1'b0;
                    n_state = r_boot ? S_IDLE : S_DONE;
                end
            end
            S_ADD1: begin
                head_we = 1'b1;
                head_wa = r_u;
                head_wd = arc_f;
                arc_we = 1'b1;
                arc_wa = arc_f;
                arc_wd = '{next: r_head_rd, target: r_v, cost: r_cost};
                head_ra = r_v;
                n_state = S_ADD2;
            end
            S_ADD2: begin
                // head of v may be the arc just linked when u equals v
                head_we = 1'b1;
                head_wa = r_v;
                head_wd = arc_r;
                arc_we = 1'b1;
                arc_wa = arc_r;
                arc_wd = '{next: hv, target: r_u, cost: -r_cost};
                res_we = 1'b1;
                res_wa = arc_f[AW-1:1];
                res_wd = {RW'(0), r_cap};
                n_arc_count = arc_r;
                n_res_new_arc = arc_r;
                n_state = S_DONE;
            end
            S_QRY: begin
                n_res_matched = (r_idx >= AW'(2)) && (r_idx <= r_arc_count) &&
                                (half_q != '0);
                n_state = S_DONE;
            end
            S_INIT: begin
                vtx_we = 1'b1;
                vtx_wa = r_cnt;
                vtx_wd = '{dval: COST_INF, parent: '0, inq: 1'b0, enq: '0};
                n_cnt = r_cnt + VW'(1);
                if (r_cnt == r_lim) begin
                    n_state = S_SEED;
                end
            end
            S_SEED: begin
                vtx_we = 1'b1;
                vtx_wa = r_src;
                vtx_wd = '{dval: '0, parent: '0, inq: 1'b1, enq: EW'(1)};
                q_we = 1'b1;
                q_wa = '0;
                q_wd = r_src;
                n_qh = '0;
                n_qlen = EW'(1);
                n_state = S_POP;
            end
            S_POP: begin
                if (r_qlen == '0) begin
                    vtx_ra = r_snk;
                    n_state = S_TCHK;
                end else begin
                    q_ra = r_qh;
                    n_qh = r_qh + VW'(1);
                    n_qlen = r_qlen - EW'(1);
                    n_state = S_POP2;
                end
            end
            S_POP2: begin
                n_u = r_q_rd;
                vtx_ra = r_q_rd;
                head_ra = r_q_rd;
                n_state = S_POP3;
            end
            S_POP3: begin
                n_du = r_vtx_rd.dval;
                vtx_we = 1'b1;
                vtx_wa = r_u;
                vtx_wd = r_vtx_rd;
                vtx_wd.inq = 1'b0;
                n_a = r_head_rd;
                n_state = S_SCAN;
            end
            S_SCAN: begin
                if (r_a == '0) begin
                    n_state = S_POP;
                end else begin
                    arc_ra = r_a;
                    res_ra = r_a[AW-1:1];
                    n_state = S_ARC;
                end
            end
            S_ARC: begin
                n_next = r_arc_rd.next;
                n_tgt = r_arc_rd.target;
                n_nd = r_du + {{(DW-CW){r_arc_rd.cost[CW-1]}}, r_arc_rd.cost};
                if (half_a == '0 || r_arc_rd.target > r_lim) begin
                    n_a = r_arc_rd.next;
                    n_state = S_SCAN;
                end else begin
                    vtx_ra = r_arc_rd.target;
                    n_state = S_RELAX;
                end
            end
            S_RELAX: begin
                n_a = r_next;
                n_state = S_SCAN;
                if ($signed(r_nd) < $signed(r_vtx_rd.dval)) begin
                    if ($signed(r_nd) < $signed(COST_NEG_INF)) begin
                        n_state = S_DONE;
                    end else begin
                        vtx_we = 1'b1;
                        vtx_wa = r_tgt;
                        vtx_wd = r_vtx_rd;
                        vtx_wd.dval = r_nd;
                        vtx_wd.parent = r_a;
                        // self loop lowers the distance of the vertex being scanned
                        if (r_tgt == r_u) begin
                            n_du = r_nd;
                        end
                        if (!r_vtx_rd.inq) begin
                            if (r_vtx_rd.enq >= lim_p1) begin
                                n_state = S_DONE;
                            end else begin
                                vtx_wd.inq = 1'b1;
                                vtx_wd.enq = r_vtx_rd.enq + EW'(1);
                                q_we = 1'b1;
                                q_wa = r_qh + r_qlen[VW-1:0];
                                q_wd = r_tgt;
                                n_qlen = r_qlen + EW'(1);
                            end
                        end
                    end
                end
            end
            S_TCHK: begin
                n_dt = r_vtx_rd.dval;
                if ($signed(r_vtx_rd.dval) >= $signed(COST_INF)) begin
                    n_state = S_DONE;
                end else begin
                    n_w = r_snk;
                    n_steps = '0;
                    n_b = '1;
                    n_pass = 1'b0;
                    n_state = S_W0;
                end
            end
            S_W0: begin
                if (r_w == r_src) begin
                    if (!r_pass) begin
                        if (r_b == '0) begin
                            n_state = S_DONE;
                        end else begin
                            n_pass = 1'b1;
                            n_w = r_snk;
                        end
                    end else begin
                        n_state = S_MUL0;
                    end
                end else if (!r_pass && r_steps >= lim_p1) begin
                    n_state = S_DONE;
                end else begin
                    n_steps = r_steps + EW'(1);
                    vtx_ra = r_w;
                    n_state = S_W1;
                end
            end
            S_W1: begin
                n_a = r_vtx_rd.parent;
                res_ra = r_vtx_rd.parent[AW-1:1];
                arc_ra = {r_vtx_rd.parent[AW-1:1], ~r_vtx_rd.parent[0]};
                n_state = S_W2;
            end
            S_W2: begin
                if (!r_pass) begin
                    if (half_a < r_b) begin
                        n_b = half_a;
                    end
                end else begin
                    res_we = 1'b1;
                    res_wa = r_a[AW-1:1];
                    if (r_a[0]) begin
                        res_wd = {r_res_rd[2*RW-1:RW] - r_b, r_res_rd[RW-1:0] + r_b};
                    end else begin
                        res_wd = {r_res_rd[2*RW-1:RW] + r_b, r_res_rd[RW-1:0] - r_b};
                    end
                end
                // tail of the parent arc is the head of its partner
                n_w = r_arc_rd.target;
                n_state = S_W0;
            end
            S_MUL0: begin
                n_flow = r_flow + 31'(r_b);
                n_prod = mul_p;
                n_state = S_MUL1;
            end
            S_MUL1: begin
                n_cost_acc = r_cost_acc + DW'(r_prod);
                n_prod = mul_p;
                n_state = S_MUL2;
            end
            S_MUL2: begin
                n_cost_acc = r_cost_acc + {r_prod[31:0], 32'b0};
                n_cnt = '0;
                n_state = S_INIT;
            end
            S_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid = 1'b1;
                    n_o_new_arc = r_res_new_arc;
                    n_o_flow = r_flow;
                    n_o_cost = r_cost_acc;
                    n_o_matched = r_res_matched;
                    n_o_status = r_res_status;
                    // an aborted search may leave vertices queued
                    n_qlen = '0;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_boot <= 1'b1;
            r_cnt <= '0;
            r_arc_count <= AW'(1);
            r_qlen <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_boot <= n_boot;
            r_cnt <= n_cnt;
            r_arc_count <= n_arc_count;
            r_qlen <= n_qlen;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_u <= n_u;
        r_v <= n_v;
        r_cap <= n_cap;
        r_cost <= n_cost;
        r_idx <= n_idx;
        r_qh <= n_qh;
        r_du <= n_du;
        r_nd <= n_nd;
        r_dt <= n_dt;
        r_a <= n_a;
        r_next <= n_next;
        r_tgt <= n_tgt;
        r_w <= n_w;
        r_steps <= n_steps;
        r_b <= n_b;
        r_pass <= n_pass;
        r_prod <= n_prod;
        r_flow <= n_flow;
        r_cost_acc <= n_cost_acc;
        r_res_new_arc <= n_res_new_arc;
        r_res_matched <= n_res_matched;
        r_res_status <= n_res_status;
        r_o_new_arc <= n_o_new_arc;
        r_o_flow <= n_o_flow;
        r_o_cost <= n_o_cost;
        r_o_matched <= n_o_matched;
        r_o_status <= n_o_status;
    end

`ifndef ASSERT_OFF
    a_arc_count_odd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_arc_count[0])
        else $error("arc count lost its pair alignment");

    a_queue_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_qlen <= lim_p1)
        else $error("work queue holds more vertices than exist");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> (r_state != S_IDLE))
        else $error("request accepted without leaving idle");

    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> ($past(r_state) == S_DONE))
        else $error("result shown without finishing a request");
`endif

endmodule

// ===== tb/sv/min_cost_max_flow_spfa_top_tb.sv =====
// ---------------------------------------------------------------------------
// min_cost_max_flow_spfa_top_tb
// Self-checking bench for the min-cost max-flow engine. A predictor that
// holds its own copy of the graph tables works out each expected result as
// a request is accepted. Every result is checked field by field in order.
// ---------------------------------------------------------------------------
module min_cost_max_flow_spfa_top_tb;
    import mcmf_pkg::*;

    localparam int WATCHDOG_LIMIT = 400000;

    typedef struct {
        logic [AW-1:0]     new_arc;
        logic [30:0]       flow;
        logic signed [63:0] cost;
        logic              matched;
        logic              status;
    } flow_result_t;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_in_valid;
    logic               o_in_stall;
    logic [1:0]         i_func;
    logic [VW-1:0]      i_from_vertex;
    logic [VW-1:0]      i_to_vertex;
    logic [15:0]        i_capacity;
    logic signed [31:0] i_edge_cost;
    logic [AW-1:0]      i_arc_index;
    logic               o_out_valid;
    logic               i_out_stall;
    logic [AW-1:0]      o_new_arc;
    logic [30:0]        o_total_flow;
    logic signed [63:0] o_total_cost;
    logic               o_matched;
    logic               o_status;
    logic               i_cfg_we;
    logic [1:0]         i_cfg_index;
    logic [VW-1:0]      i_cfg_data;

    min_cost_max_flow_spfa_top dut (.*);

    // predictor copy of the graph
    int unsigned adj_head    [MAX_VERTICES];
    int unsigned arc_next    [MAX_ARCS];
    int unsigned arc_head    [MAX_ARCS];
    int unsigned arc_resid   [MAX_ARCS];
    longint      arc_weight  [MAX_ARCS];
    longint      vtx_dist    [MAX_VERTICES];
    int unsigned vtx_parent  [MAX_VERTICES];
    int unsigned search_fifo [MAX_VERTICES];
    bit          vtx_queued  [MAX_VERTICES];
    int unsigned vtx_enq     [MAX_VERTICES];
    int unsigned arc_top;
    int unsigned nodes_top, src_v, snk_v;

    flow_result_t results_due[$];
    int  errors;
    int  requests_sent;
    int  results_seen;
    int  flows_found;
    int  idle_cycles;
    bit  quiet;
    int  stall_hold;

    function automatic bit spfa_search(int unsigned s, int unsigned lim);
        int unsigned qh, qlen, u, a, steps, v;
        longint nd;
        qh = 0;
        for (v = 0; v <= lim; v++) begin
            vtx_dist[v] = COST_INF;
            vtx_queued[v] = 0;
            vtx_enq[v] = 0;
        end
        vtx_dist[s] = 0;
        search_fifo[0] = s;
        vtx_queued[s] = 1;
        vtx_enq[s] = 1;
        qlen = 1;
        while (qlen != 0) begin
            u = search_fifo[qh];
            qh = (qh + 1) % MAX_VERTICES;
            qlen--;
            vtx_queued[u] = 0;
            a = adj_head[u];
            steps = 0;
            while (a != 0 && a < MAX_ARCS && steps < MAX_ARCS) begin
                if (arc_resid[a] != 0 && arc_head[a] <= lim) begin
                    v = arc_head[a];
                    nd = vtx_dist[u] + arc_weight[a];
                    if (nd < vtx_dist[v]) begin
                        if (nd < COST_NEG_INF) return 1;
                        vtx_dist[v] = nd;
                        vtx_parent[v] = a;
                        if (!vtx_queued[v]) begin
                            if (vtx_enq[v] >= lim + 1) return 1;
                            vtx_enq[v]++;
                            search_fifo[(qh + qlen) % MAX_VERTICES] = v;
                            qlen++;
                            vtx_queued[v] = 1;
                        end
                    end
                end
                a = arc_next[a];
                steps++;
            end
        end
        return 0;
    endfunction

    function automatic void augment_all(output logic [30:0] flow_o,
                                        output logic [63:0] cost_o);
        int unsigned lim, u, a, b, steps, flow;
        logic [63:0] cost;
        bit ok;
        lim = (nodes_top < MAX_VERTICES) ? nodes_top : MAX_VERTICES - 1;
        flow = 0;
        cost = 0;
        a = 0;
        if (src_v <= lim && snk_v <= lim && src_v != snk_v) begin
            forever begin
                b = 32'hFFFF_FFFF;
                steps = 0;
                ok = 1;
                if (spfa_search(src_v, lim)) break;
                if (vtx_dist[snk_v] >= COST_INF) break;
                for (u = snk_v; u != src_v; u = arc_head[(a ^ 1) % MAX_ARCS] % MAX_VERTICES) begin
                    steps++;
                    if (steps > lim + 1) begin
                        ok = 0;
                        break;
                    end
                    a = vtx_parent[u] % MAX_ARCS;
                    if (arc_resid[a] < b) b = arc_resid[a];
                end
                if (!ok || b == 0) break;
                for (u = snk_v; u != src_v; u = arc_head[(a ^ 1) % MAX_ARCS] % MAX_VERTICES) begin
                    a = vtx_parent[u] % MAX_ARCS;
                    arc_resid[a] -= b;
                    arc_resid[(a ^ 1) % MAX_ARCS] += b;
                end
                flow += b;
                cost += 64'(vtx_dist[snk_v]) * 64'(b);
            end
        end
        flow_o = flow[30:0];
        cost_o = cost;
    endfunction

    function automatic flow_result_t predict_result(logic [1:0] fn, int unsigned fu,
            int unsigned tv, int unsigned cap, logic signed [31:0] c, int unsigned idx);
        flow_result_t r;
        int unsigned lim, f, rv;
        logic [63:0] cost;
        r = '{default: 0};
        lim = (nodes_top < MAX_VERTICES) ? nodes_top : MAX_VERTICES - 1;
        case (fn)
            FUNC_CLEAR: begin
                foreach (adj_head[i]) adj_head[i] = 0;
                arc_top = 1;
            end
            FUNC_ADD: begin
                if (fu > lim || tv > lim || arc_top + 2 > MAX_ARCS - 1) begin
                    r.status = 1;
                end else begin
                    f = arc_top + 1;
                    rv = arc_top + 2;
                    arc_next[f] = adj_head[fu]; adj_head[fu] = f;
                    arc_head[f] = tv; arc_resid[f] = cap; arc_weight[f] = longint'(c);
                    arc_next[rv] = adj_head[tv]; adj_head[tv] = rv;
                    arc_head[rv] = fu; arc_resid[rv] = 0; arc_weight[rv] = -longint'(c);
                    arc_top = rv;
                    r.new_arc = rv[AW-1:0];
                end
            end
            FUNC_SOLVE: begin
                augment_all(r.flow, cost);
                r.cost = cost;
                if (r.flow != 0) flows_found++;
            end
            default: begin
                if (idx >= 2 && idx <= arc_top && idx < MAX_ARCS)
                    r.matched = arc_resid[idx] != 0;
            end
        endcase
        return r;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic send_request(logic [1:0] fn, int unsigned fu = 0, int unsigned tv = 0,
            int unsigned cap = 0, logic signed [31:0] c = 0, int unsigned idx = 0);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            i_in_valid <= 0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid    <= 1;
        i_func        <= fn;
        i_from_vertex <= fu[VW-1:0];
        i_to_vertex   <= tv[VW-1:0];
        i_capacity    <= cap[15:0];
        i_edge_cost   <= c;
        i_arc_index   <= idx[AW-1:0];
        do @(posedge i_clk); while (o_in_stall);
        results_due.push_back(predict_result(fn, fu[VW-1:0], tv[VW-1:0], cap[15:0], c,
                                             idx[AW-1:0]));
        requests_sent++;
    endtask

    task automatic drain();
        i_in_valid <= 0;
        while (results_due.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [1:0] idx, int unsigned val);
        drain();
        i_cfg_we    <= 1;
        i_cfg_index <= idx;
        i_cfg_data  <= val[VW-1:0];
        @(posedge i_clk);
        i_cfg_we    <= 0;
        case (idx)
            CFG_VERTEX_COUNT: nodes_top = val[VW-1:0];
            CFG_SOURCE:       src_v = val[VW-1:0];
            default:          snk_v = val[VW-1:0];
        endcase
    endtask

    task automatic set_graph(int unsigned n, int unsigned s, int unsigned t);
        write_reg(CFG_VERTEX_COUNT, n);
        write_reg(CFG_SOURCE, s);
        write_reg(CFG_SINK, t);
    endtask

    task automatic test_reset_state();
        send_request(FUNC_SOLVE);
        send_request(FUNC_QUERY, 0, 0, 0, 0, 0);
        send_request(FUNC_QUERY, 0, 0, 0, 0, 1);
        send_request(FUNC_QUERY, 0, 0, 0, 0, MAX_ARCS - 1);
        send_request(FUNC_ADD, 0, 0, 65535, 32'sd7);
        send_request(FUNC_ADD, 1, 0, 5, 32'sd1);
        send_request(FUNC_QUERY, 0, 0, 0, 0, 2);
        send_request(FUNC_CLEAR);
    endtask

    task automatic test_small_flow();
        set_graph(3, 0, 3);
        send_request(FUNC_ADD, 0, 1, 65535, 32'sh7FFF_FFFF);
        send_request(FUNC_ADD, 0, 2, 40, -32'sd3);
        send_request(FUNC_ADD, 1, 3, 30, 32'sh8000_0000);
        send_request(FUNC_ADD, 2, 3, 65535, 32'sd10);
        send_request(FUNC_ADD, 2, 1, 0, 32'sd0);
        send_request(FUNC_ADD, 4, 1, 9, 32'sd0);
        send_request(FUNC_SOLVE);
        for (int i = 0; i < 12; i++) send_request(FUNC_QUERY, 0, 0, 0, 0, i);
        send_request(FUNC_SOLVE);
        // source equal to sink, then source out of range, then sink out of range
        write_reg(CFG_SOURCE, 3);
        send_request(FUNC_SOLVE);
        write_reg(CFG_SOURCE, 1023);
        send_request(FUNC_SOLVE);
        write_reg(CFG_SOURCE, 0);
        write_reg(CFG_SINK, 1023);
        send_request(FUNC_SOLVE);
    endtask

    task automatic test_shrunk_graph();
        set_graph(7, 0, 5);
        send_request(FUNC_CLEAR);
        send_request(FUNC_ADD, 0, 7, 100, 32'sd1);
        send_request(FUNC_ADD, 7, 5, 100, 32'sd1);
        send_request(FUNC_ADD, 0, 5, 20, 32'sd50);
        // arcs into vertex 7 are dropped once it lies beyond the graph
        write_reg(CFG_VERTEX_COUNT, 5);
        send_request(FUNC_SOLVE);
        write_reg(CFG_VERTEX_COUNT, 7);
        send_request(FUNC_SOLVE);
    endtask

    task automatic test_negative_cycle();
        set_graph(3, 0, 3);
        send_request(FUNC_CLEAR);
        send_request(FUNC_ADD, 0, 1, 10, 32'sd2);
        send_request(FUNC_ADD, 1, 2, 10, -32'sd5);
        send_request(FUNC_ADD, 2, 1, 10, -32'sd5);
        send_request(FUNC_ADD, 1, 3, 10, 32'sd1);
        send_request(FUNC_SOLVE);
        send_request(FUNC_QUERY, 0, 0, 0, 0, 2);
    endtask

    task automatic test_random_graphs(int target);
        int unsigned n, edges;
        int stop_at;
        stop_at = requests_sent + target;
        while (requests_sent < stop_at) begin
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 1) : $urandom_range(2, 15);
            quiet = $urandom_range(0, 5) == 0;
            set_graph(n, $urandom_range(0, n + 1), $urandom_range(0, n + 1));
            send_request(FUNC_CLEAR);
            edges = $urandom_range(2, 25);
            for (int e = 0; e < edges; e++) begin
                case ($urandom_range(0, 9))
                    0: send_request(FUNC_QUERY, 0, 0, 0, 0, $urandom_range(0, MAX_ARCS - 1));
                    1: send_request(FUNC_SOLVE);
                    2: send_request(FUNC_ADD, $urandom_range(0, n + 2), $urandom_range(0, n + 2),
                                    $urandom_range(0, 65535), $urandom);
                    default: send_request(FUNC_ADD, $urandom_range(0, n), $urandom_range(0, n),
                                    $urandom_range(0, 65535),
                                    ($urandom_range(0, 3) == 0) ? $urandom
                                                                : $urandom_range(0, 2000) - 500);
                endcase
            end
            send_request(FUNC_SOLVE);
            for (int q = 0; q < 4; q++)
                send_request(FUNC_QUERY, 0, 0, 0, 0, $urandom_range(0, 2 * edges + 3));
        end
        quiet = 0;
    endtask

    task automatic test_wide_graph();
        set_graph(1023, 0, 1023);
        send_request(FUNC_CLEAR);
        for (int i = 0; i < 30; i++)
            send_request(FUNC_ADD, $urandom_range(0, 1023), $urandom_range(0, 1023),
                         $urandom_range(0, 65535), $urandom_range(0, 32'h7FFF_FFFF));
        send_request(FUNC_ADD, 0, 512, 1000, 32'sd4);
        send_request(FUNC_ADD, 512, 1023, 700, 32'sd6);
        send_request(FUNC_ADD, 0, 1023, 65535, 32'sh7FFF_FFFF);
        send_request(FUNC_SOLVE);
        for (int i = 0; i < 8; i++)
            send_request(FUNC_QUERY, 0, 0, 0, 0, $urandom_range(0, MAX_ARCS - 1));
        send_request(FUNC_SOLVE);
        send_request(FUNC_CLEAR);
    endtask

    initial begin
        i_clk = 0;
        forever #4 i_clk = ~i_clk;
    end

    // receiver back-pressure
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 0;
            stall_hold  <= 0;
        end else if (stall_hold > 0) begin
            stall_hold <= stall_hold - 1;
        end else if (quiet) begin
            i_out_stall <= 0;
        end else begin
            i_out_stall <= $urandom_range(0, 2) == 0;
            stall_hold  <= ($urandom_range(0, 19) == 0) ? $urandom_range(10, 50)
                                                        : $urandom_range(0, 3);
        end
    end

    always @(posedge i_clk) begin
        flow_result_t exp_r;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            results_seen++;
            if (results_due.size() == 0) begin
                $display("%0t: result with no request pending", $time);
                errors++;
            end else begin
                exp_r = results_due.pop_front();
                if (o_new_arc !== exp_r.new_arc) begin
                    $display("%0t: new_arc exp %0d got %0d", $time, exp_r.new_arc, o_new_arc);
                    errors++;
                end
                if (o_total_flow !== exp_r.flow) begin
                    $display("%0t: total_flow exp %0d got %0d", $time, exp_r.flow,
                             o_total_flow);
                    errors++;
                end
                if (o_total_cost !== exp_r.cost) begin
                    $display("%0t: total_cost exp %0d got %0d", $time, exp_r.cost,
                             o_total_cost);
                    errors++;
                end
                if (o_matched !== exp_r.matched) begin
                    $display("%0t: matched exp %0d got %0d", $time, exp_r.matched, o_matched);
                    errors++;
                end
                if (o_status !== exp_r.status) begin
                    $display("%0t: status exp %0d got %0d", $time, exp_r.status, o_status);
                    errors++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no progress, %0d results outstanding", $time, results_due.size());
            $display("simulation failed");
            $finish;
        end
    end

    initial begin
        errors = 0; requests_sent = 0; results_seen = 0; flows_found = 0;
        idle_cycles = 0; quiet = 0;
        foreach (adj_head[i]) begin
            adj_head[i] = 0; vtx_dist[i] = 0; vtx_parent[i] = 0;
            search_fifo[i] = 0; vtx_queued[i] = 0; vtx_enq[i] = 0;
        end
        foreach (arc_next[i]) begin
            arc_next[i] = 0; arc_head[i] = 0; arc_resid[i] = 0; arc_weight[i] = 0;
        end
        arc_top = 1; nodes_top = 0; src_v = 0; snk_v = 1;
        i_rst_n <= 0; i_in_valid <= 0; i_func <= FUNC_CLEAR;
        i_from_vertex <= 0; i_to_vertex <= 0; i_capacity <= 0; i_edge_cost <= 0;
        i_arc_index <= 0; i_cfg_we <= 0; i_cfg_index <= CFG_VERTEX_COUNT; i_cfg_data <= 0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        test_reset_state();
        test_small_flow();
        test_shrunk_graph();
        test_negative_cycle();
        test_wide_graph();
        test_random_graphs(660);
        drain();
        repeat (50) @(posedge i_clk);

        $display("%0d requests sent, %0d results checked", requests_sent, results_seen);
        $display("%0d solves pushed flow; rejected adds, shrunk and cyclic graphs covered",
                 flows_found);
        if (errors == 0 && results_due.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/mcmf_pkg.sv
rtl/min_cost_max_flow_spfa_top.sv
tb/sv/min_cost_max_flow_spfa_top_tb.sv
